// ===== hdl/sas_pkg.sv =====
// Package for the sorted array store: command and status codes, the
// controller-to-datapath command and status structs.
// No dependencies.
package sas_pkg;

    localparam int CMD_W  = 3;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 4;

    // command codes
    localparam logic [CMD_W-1:0] OP_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] OP_LIST   = 3'd1;
    localparam logic [CMD_W-1:0] OP_FIND   = 3'd2;
    localparam logic [CMD_W-1:0] OP_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] OP_CLEAR  = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {K_HOLD, K_CLR, K_LOAD_N, K_INC, K_DEC} t_k_op;
    typedef enum logic [1:0] {N_HOLD, N_INC, N_DEC, N_CLR} t_n_op;
    typedef enum logic [1:0] {POS_ZERO, POS_K, POS_FOUND} t_pos_sel;
    typedef enum logic {ADR_K, ADR_KM1} t_adr_sel;
    typedef enum logic {WD_VAL, WD_DATA} t_wd_sel;

    typedef struct packed {
        logic              capture;
        t_k_op             k_op;
        logic              rd;
        t_adr_sel          rd_adr;
        logic              wr;
        t_adr_sel          wr_adr;
        t_wd_sel           wr_src;
        t_n_op             n_op;
        logic              found_set;
        logic              found_clr;
        logic              res_load;
        logic [STAT_W-1:0] res_status;
        t_pos_sel          res_pos;
        logic              res_last;
        logic              res_data;
        logic              out_load;
    } t_sas_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             full;
        logic             empty;
        logic             k_zero;
        logic             at_end;
        logic             last_item;
        logic             gt;
        logic             eq;
        logic             found;
        logic             res_last;
        logic             out_free;
    } t_sas_sts;

endpackage

// ===== hdl/sas_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module sas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sas_dp.sv =====
// Datapath of the sorted array store: operand and cursor registers, fill
// count, entry RAM, compare logic and the output register.
// Depends on sas_pkg and sas_ram.
module sas_dp #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sas_pkg::t_sas_cmd        i_cmd,
    output sas_pkg::t_sas_sts        o_sts,
    input  logic [sas_pkg::CMD_W-1:0] i_in_cmd,
    input  logic [sas_pkg::VAL_W-1:0] i_in_val,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [sas_pkg::STAT_W-1:0] o_out_status,
    output logic [sas_pkg::POS_W-1:0]  o_out_pos,
    output logic [sas_pkg::VAL_W-1:0]  o_out_value,
    output logic                     o_out_last
);
    import sas_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    logic [CMD_W-1:0]         r_op;
    logic signed [VAL_W-1:0]  r_operand;
    logic [CW-1:0]            r_k, n_k;
    logic [CW-1:0]            r_n, n_n;
    logic                     r_found;
    logic [POS_W-1:0]         r_found_pos;
    logic [STAT_W-1:0]        r_res_status;
    logic [POS_W-1:0]         r_res_pos;
    logic                     r_res_last;
    logic                     r_res_data;
    logic                     r_out_valid;
    logic [STAT_W-1:0]        r_out_status;
    logic [POS_W-1:0]         r_out_pos;
    logic [VAL_W-1:0]         r_out_value;
    logic                     r_out_last;

    logic [CW-1:0]            w_km1;
    logic [CW-1:0]            w_kp1;
    logic [CW+POS_W-1:0]      w_kext;
    logic [POS_W-1:0]         w_pos_k;
    logic [POS_W-1:0]         w_res_pos;
    logic [IW-1:0]            w_raddr;
    logic [IW-1:0]            w_waddr;
    logic [VAL_W-1:0]         w_wdata;
    logic [VAL_W-1:0]         w_rdata;
    logic                     w_out_free;

    assign w_km1   = r_k - 1'b1;
    assign w_kp1   = r_k + 1'b1;
    assign w_kext  = {{POS_W{1'b0}}, r_k};
    assign w_pos_k = w_kext[POS_W-1:0];

    assign w_raddr = (i_cmd.rd_adr == ADR_KM1) ? w_km1[IW-1:0] : r_k[IW-1:0];
    assign w_waddr = (i_cmd.wr_adr == ADR_KM1) ? w_km1[IW-1:0] : r_k[IW-1:0];
    assign w_wdata = (i_cmd.wr_src == WD_DATA) ? w_rdata : r_operand;

    sas_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        unique case (i_cmd.k_op)
            K_CLR:    n_k = '0;
            K_LOAD_N: n_k = r_n;
            K_INC:    n_k = w_kp1;
            K_DEC:    n_k = w_km1;
            default:  n_k = r_k;
        endcase
    end

    always_comb begin
        unique case (i_cmd.n_op)
            N_INC:   n_n = r_n + 1'b1;
            N_DEC:   n_n = r_n - 1'b1;
            N_CLR:   n_n = '0;
            default: n_n = r_n;
        endcase
    end

    always_comb begin
        unique case (i_cmd.res_pos)
            POS_K:     w_res_pos = w_pos_k;
            POS_FOUND: w_res_pos = r_found_pos;
            default:   w_res_pos = '0;
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_n <= n_n;
            if (i_cmd.found_clr) begin
                r_found <= 1'b0;
            end else if (i_cmd.found_set) begin
                r_found <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (i_cmd.capture) begin
            r_op      <= i_in_cmd;
            r_operand <= i_in_val;
        end
        if (i_cmd.found_set) begin
            r_found_pos <= w_pos_k;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_pos    <= w_res_pos;
            r_res_last   <= i_cmd.res_last;
            r_res_data   <= i_cmd.res_data;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_pos    <= r_res_pos;
            r_out_value  <= r_res_data ? w_rdata : '0;
            r_out_last   <= r_res_last;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.full      = (r_n == DEPTH_CNT);
    assign o_sts.empty     = (r_n == '0);
    assign o_sts.k_zero    = (r_k == '0);
    assign o_sts.at_end    = (r_k == r_n);
    assign o_sts.last_item = (w_kp1 == r_n);
    assign o_sts.gt        = ($signed(w_rdata) > r_operand);
    assign o_sts.eq        = ($signed(w_rdata) == r_operand);
    assign o_sts.found     = r_found;
    assign o_sts.res_last  = r_res_last;
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_pos    = r_out_pos;
    assign o_out_value  = r_out_value;
    assign o_out_last   = r_out_last;

endmodule

// ===== hdl/sas_ctrl.sv =====
// Controller of the sorted array store: sequences each command over the
// entry RAM and the output register. Depends on sas_pkg.
module sas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sas_pkg::t_sas_sts i_sts,
    output sas_pkg::t_sas_cmd o_cmd
);
    import sas_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DISP    = 3'd1;
    localparam logic [2:0] S_INS_CHK = 3'd2;
    localparam logic [2:0] S_INS_EV  = 3'd3;
    localparam logic [2:0] S_RD      = 3'd4;
    localparam logic [2:0] S_EV      = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    logic [2:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.res_last = 1'b1;
                unique case (i_sts.op)
                    OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_FULL;
                            n_state          = S_EMIT;
                        end else begin
                            o_cmd.k_op = K_LOAD_N;
                            n_state    = S_INS_CHK;
                        end
                    end
                    OP_LIST, OP_DELETE: begin
                        if (i_sts.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_EMPTY;
                            n_state          = S_EMIT;
                        end else begin
                            o_cmd.k_op      = K_CLR;
                            o_cmd.found_clr = 1'b1;
                            n_state         = S_RD;
                        end
                    end
                    OP_FIND: begin
                        o_cmd.k_op = K_CLR;
                        n_state    = S_RD;
                    end
                    OP_CLEAR: begin
                        o_cmd.n_op       = N_CLR;
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_EMIT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_INS_CHK: begin
                // slot k is free; bottom reached means the value lands at 0
                if (i_sts.k_zero) begin
                    o_cmd.wr         = 1'b1;
                    o_cmd.wr_src     = WD_VAL;
                    o_cmd.n_op       = N_INC;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_pos    = POS_K;
                    o_cmd.res_last   = 1'b1;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_adr = ADR_KM1;
                    n_state      = S_INS_EV;
                end
            end
            S_INS_EV: begin
                o_cmd.wr = 1'b1;
                if (i_sts.gt) begin
                    // move the larger entry up one slot
                    o_cmd.wr_src = WD_DATA;
                    o_cmd.k_op   = K_DEC;
                    n_state      = S_INS_CHK;
                end else begin
                    o_cmd.wr_src     = WD_VAL;
                    o_cmd.n_op       = N_INC;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_pos    = POS_K;
                    o_cmd.res_last   = 1'b1;
                    n_state          = S_EMIT;
                end
            end
            S_RD: begin
                if (i_sts.at_end) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_last = 1'b1;
                    if (i_sts.op == OP_DELETE && i_sts.found) begin
                        o_cmd.n_op       = N_DEC;
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_pos    = POS_FOUND;
                    end else begin
                        o_cmd.res_status = ST_NOTFOUND;
                    end
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EV;
                end
            end
            S_EV: begin
                priority if (i_sts.op == OP_LIST) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_pos    = POS_K;
                    o_cmd.res_last   = i_sts.last_item;
                    o_cmd.res_data   = 1'b1;
                    n_state          = S_EMIT;
                end else if (i_sts.op == OP_FIND && i_sts.eq) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_pos    = POS_K;
                    o_cmd.res_last   = 1'b1;
                    n_state          = S_EMIT;
                end else begin
                    // delete: after the match, pull each entry down one slot
                    if (i_sts.op == OP_DELETE) begin
                        if (i_sts.found) begin
                            o_cmd.wr     = 1'b1;
                            o_cmd.wr_adr = ADR_KM1;
                            o_cmd.wr_src = WD_DATA;
                        end else if (i_sts.eq) begin
                            o_cmd.found_set = 1'b1;
                        end
                    end
                    o_cmd.k_op = K_INC;
                    n_state    = S_RD;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.op == OP_LIST && !i_sts.res_last) begin
                        o_cmd.k_op = K_INC;
                        n_state    = S_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/sorted_array_store.sv =====
// Top level of the sorted array store: stream ports around the controller
// and the datapath. Depends on sas_pkg, sas_ctrl and sas_dp.
//
// Usage: the block keeps up to DEPTH signed 32-bit values in ascending order
// (duplicates allowed). Each transfer on the slave stream carries one
// command in tuser and its operand in tdata: insert, list, find, delete or
// clear. Commands 5 to 7 are dropped without a result. Results leave on the
// master stream, status in tuser and position/value in tdata; tlast marks
// the final result of a command. List gives one result per stored entry
// (or one empty result); every other command gives exactly one result.
// One command is worked at a time; tready is high only while idle. Each
// entry visited costs one RAM read and one compare. Insert reads and moves
// up each larger entry until the value finds its slot, or lands at position
// 0; find stops at the first hit and reads every entry on a miss; delete
// always walks the whole store; list reads every entry. Reset empties the
// store at once (fill count to zero, no RAM sweep) and drops any pending
// result. When the receiver stalls, the result is held in the output
// register and the controller waits before producing the next.
module sorted_array_store #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] operand_value
    input  logic [2:0]  s_axis_tuser,  // [2:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [3:0] position, [35:4] entry_value, rest zero
    output logic [1:0]  m_axis_tuser,  // [1:0] status
    output logic        m_axis_tlast
);
    import sas_pkg::*;

    t_sas_cmd          w_cmd;
    t_sas_sts          w_sts;
    logic [POS_W-1:0]  w_pos;
    logic [VAL_W-1:0]  w_value;

    sas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sas_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_cmd     (s_axis_tuser),
        .i_in_val     (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (m_axis_tuser),
        .o_out_pos    (w_pos),
        .o_out_value  (w_value),
        .o_out_last   (m_axis_tlast)
    );

    // pack position and value, pad to whole bytes
    assign m_axis_tdata = {4'b0000, w_value, w_pos};

endmodule
